[hw/rtl/tlg_pkg.sv]
// shared types, codes and helpers of the toroidal life grid
// no dependencies; imported by every module of the block but tlg_cell_mem
package tlg_pkg;

    localparam int CELL_W  = 6;
    localparam int FADE_W  = 5;
    localparam int DIM_W   = 7;
    localparam int SHADE_W = 3;
    localparam int CNT_W   = 4;

    localparam logic [FADE_W-1:0]  FADE_LIMIT  = 5'd20;
    localparam logic [DIM_W-1:0]   DIM_MIN     = 7'd3;
    localparam logic [CNT_W-1:0]   SURVIVE_MIN = 4'd2;
    localparam logic [CNT_W-1:0]   BIRTH_COUNT = 4'd3;
    localparam logic [SHADE_W-1:0] SHADE_BLACK = 3'd0;
    localparam logic [SHADE_W-1:0] SHADE_ALIVE = 3'd6;

    typedef enum logic [1:0] {
        KIND_WRITE = 2'd0,
        KIND_READ  = 2'd1,
        KIND_STEP  = 2'd2
    } t_kind;

    typedef enum logic [1:0] {
        CFG_GRID_WIDTH  = 2'd0,
        CFG_GRID_HEIGHT = 2'd1,
        CFG_FADE_START  = 2'd2
    } t_cfg_idx;

    // row of the 3x3 window a source read belongs to
    typedef enum logic [1:0] {
        ROW_ABOVE = 2'd0,
        ROW_MID   = 2'd1,
        ROW_BELOW = 2'd2
    } t_win_row;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_WRITE,
        ST_RESULT,
        ST_GEN,
        ST_DRAIN
    } t_state;

    typedef struct packed {
        logic     capture;
        t_win_row row;
    } t_win_ctrl;

    typedef struct packed {
        logic en;
        logic to_next;
        logic both;
    } t_wr_sel;

    typedef struct packed {
        logic load;
        logic zero;
    } t_res_ctrl;

    function automatic logic [SHADE_W-1:0] shade_of(input logic alive,
                                                    input logic [FADE_W-1:0] fade);
        logic [SHADE_W-1:0] s;
        if (alive) begin
            s = SHADE_ALIVE;
        end else if (fade inside {[5'd17:5'd20]}) begin
            s = 3'd5;
        end else if (fade inside {[5'd13:5'd16]}) begin
            s = 3'd4;
        end else if (fade inside {[5'd9:5'd12]}) begin
            s = 3'd3;
        end else if (fade inside {[5'd5:5'd8]}) begin
            s = 3'd2;
        end else if (fade inside {[5'd1:5'd4]}) begin
            s = 3'd1;
        end else begin
            s = SHADE_BLACK;
        end
        return s;
    endfunction

endpackage

[hw/rtl/toroidal_life_grid_with_fade.sv]
// Life grid on a torus with a fade counter per cell, kept in two cell rams that
// swap roles after every generation. After reset the block clears both rams, one
// cell per cycle, before it takes its first item; configuration writes are taken
// throughout. A write item reads the cell, then writes it back with the fade kept;
// a read item reads the cell, then may wait for the result register to drain. In a
// step item the single read port of the current ram feeds the 3x3 window one cell
// per cycle, three reads for each window column, with two extra columns per row
// for the wrap.
module toroidal_life_grid_with_fade #(
    parameter int MAX_COLS = 64,
    parameter int MAX_ROWS = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [6:0]  i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_kind,
    input  logic [5:0]  i_col,
    input  logic [5:0]  i_row,
    input  logic        i_alive_in,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic        o_alive_out,
    output logic [4:0]  o_fade_out,
    output logic [2:0]  o_shade
);
    import tlg_pkg::*;

    localparam int CELL_COUNT = MAX_COLS * MAX_ROWS;
    localparam int AW         = $clog2(CELL_COUNT);

    logic [DIM_W-1:0]   r_grid_width;
    logic [DIM_W-1:0]   r_grid_height;
    logic [FADE_W-1:0]  r_fade_start;
    logic [DIM_W-1:0]   eff_w;
    logic [DIM_W-1:0]   eff_h;
    logic [FADE_W-1:0]  eff_fs;

    logic               r_out_valid;
    logic               r_alive_out;
    logic [FADE_W-1:0]  r_fade_out;
    logic [SHADE_W-1:0] r_shade;
    logic               out_busy;

    logic               rd_en;
    logic [AW-1:0]      rd_addr;
    t_wr_sel            wr_sel;
    logic [AW-1:0]      wr_addr;
    logic [CELL_W-1:0]  wr_data;
    t_win_ctrl          win;
    t_res_ctrl          res;
    logic               active;
    logic               wr_target;
    logic [CELL_W-1:0]  rd_data_a;
    logic [CELL_W-1:0]  rd_data_b;
    logic [CELL_W-1:0]  rd_data;
    logic [CELL_W-1:0]  next_cell;
    logic [CELL_W-1:0]  res_cell;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_width  <= 7'd64;
            r_grid_height <= 7'd64;
            r_fade_start  <= FADE_LIMIT;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_GRID_WIDTH:  r_grid_width  <= i_cfg_data;
                CFG_GRID_HEIGHT: r_grid_height <= i_cfg_data;
                CFG_FADE_START:  r_fade_start  <= i_cfg_data[FADE_W-1:0];
                default: ;
            endcase
        end
    end

    // sizes in use, held to 3..MAX, and the fade start held to FADE_LIMIT
    always_comb begin
        if (r_grid_width < DIM_MIN) begin
            eff_w = DIM_MIN;
        end else if (int'(r_grid_width) > MAX_COLS) begin
            eff_w = DIM_W'(MAX_COLS);
        end else begin
            eff_w = r_grid_width;
        end
        if (r_grid_height < DIM_MIN) begin
            eff_h = DIM_MIN;
        end else if (int'(r_grid_height) > MAX_ROWS) begin
            eff_h = DIM_W'(MAX_ROWS);
        end else begin
            eff_h = r_grid_height;
        end
        eff_fs = (r_fade_start > FADE_LIMIT) ? FADE_LIMIT : r_fade_start;
    end

    tlg_ctrl #(
        .MAX_COLS (MAX_COLS),
        .MAX_ROWS (MAX_ROWS),
        .AW       (AW)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_kind      (i_kind),
        .i_col       (i_col),
        .i_row       (i_row),
        .i_alive_in  (i_alive_in),
        .i_eff_w     (eff_w),
        .i_eff_h     (eff_h),
        .i_out_busy  (out_busy),
        .i_rd_data   (rd_data),
        .i_next_cell (next_cell),
        .o_rd_en     (rd_en),
        .o_rd_addr   (rd_addr),
        .o_wr_sel    (wr_sel),
        .o_wr_addr   (wr_addr),
        .o_wr_data   (wr_data),
        .o_win       (win),
        .o_res       (res),
        .o_active    (active)
    );

    // the current store is active; a generation writes into the other one
    assign wr_target = active ^ wr_sel.to_next;

    tlg_cell_mem #(
        .DEPTH (CELL_COUNT),
        .AW    (AW),
        .DW    (CELL_W)
    ) u_grid_a (
        .i_clk     (i_clk),
        .i_wr_en   (wr_sel.en && (wr_sel.both || !wr_target)),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data_a)
    );

    tlg_cell_mem #(
        .DEPTH (CELL_COUNT),
        .AW    (AW),
        .DW    (CELL_W)
    ) u_grid_b (
        .i_clk     (i_clk),
        .i_wr_en   (wr_sel.en && (wr_sel.both || wr_target)),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data_b)
    );

    assign rd_data = active ? rd_data_b : rd_data_a;

    tlg_window u_window (
        .i_clk        (i_clk),
        .i_ctrl       (win),
        .i_rd_data    (rd_data),
        .i_fade_start (eff_fs),
        .o_next_cell  (next_cell)
    );

    // result register, frees the sequencer while a read result waits
    assign out_busy = r_out_valid && !i_out_ready;
    assign res_cell = res.zero ? '0 : rd_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res.load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res.load) begin
            r_alive_out <= res_cell[0];
            r_fade_out  <= res_cell[CELL_W-1:1];
            r_shade     <= shade_of(res_cell[0], res_cell[CELL_W-1:1]);
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_alive_out = r_alive_out;
    assign o_fade_out  = r_fade_out;
    assign o_shade     = r_shade;

endmodule

[hw/rtl/tlg_cell_mem.sv]
// one cell store: simple dual-port ram, one write and one registered read port
// depends on nothing; instantiated twice by the top level
module tlg_cell_mem #(
    parameter int DEPTH = 4096,
    parameter int AW    = 12,
    parameter int DW    = 6
) (
    input  logic          i_clk,
    input  logic          i_wr_en,
    input  logic [AW-1:0] i_wr_addr,
    input  logic [DW-1:0] i_wr_data,
    input  logic          i_rd_en,
    input  logic [AW-1:0] i_rd_addr,
    output logic [DW-1:0] o_rd_data
);

    logic [DW-1:0] r_mem [DEPTH];
    logic [DW-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

[hw/rtl/tlg_window.sv]
// 3x3 neighbourhood window fed one source cell per transfer, and the life rule
// depends on tlg_pkg; driven by tlg_ctrl
module tlg_window (
    input  logic                      i_clk,
    input  tlg_pkg::t_win_ctrl        i_ctrl,
    input  logic [tlg_pkg::CELL_W-1:0] i_rd_data,
    input  logic [tlg_pkg::FADE_W-1:0] i_fade_start,
    output logic [tlg_pkg::CELL_W-1:0] o_next_cell
);
    import tlg_pkg::*;

    // alive bits per column: [0] above, [1] middle, [2] below
    logic [2:0]        r_col_l;
    logic [2:0]        r_col_c;
    logic [2:0]        r_col_r;
    logic [FADE_W-1:0] r_fade_c;
    logic [FADE_W-1:0] r_fade_r;
    logic              r_in_top;
    logic [CELL_W-1:0] r_in_mid;

    logic [CNT_W-1:0]  cnt;
    logic              alive;
    logic [FADE_W-1:0] fade;

    always_ff @(posedge i_clk) begin
        if (i_ctrl.capture) begin
            case (i_ctrl.row)
                ROW_ABOVE: r_in_top <= i_rd_data[0];
                ROW_MID:   r_in_mid <= i_rd_data;
                ROW_BELOW: begin
                    r_col_l  <= r_col_c;
                    r_col_c  <= r_col_r;
                    r_col_r  <= {i_rd_data[0], r_in_mid[0], r_in_top};
                    r_fade_c <= r_fade_r;
                    r_fade_r <= r_in_mid[CELL_W-1:1];
                end
                default: ;
            endcase
        end
    end

    assign cnt = CNT_W'(r_col_l[0]) + CNT_W'(r_col_l[1]) + CNT_W'(r_col_l[2])
               + CNT_W'(r_col_c[0]) + CNT_W'(r_col_c[2])
               + CNT_W'(r_col_r[0]) + CNT_W'(r_col_r[1]) + CNT_W'(r_col_r[2]);

    always_comb begin
        alive = r_col_c[1];
        fade  = r_fade_c;
        if (r_col_c[1] && (cnt < SURVIVE_MIN || cnt > BIRTH_COUNT)) begin
            alive = 1'b0;
            fade  = i_fade_start;
        end else if (!r_col_c[1] && cnt == BIRTH_COUNT) begin
            alive = 1'b1;
            fade  = '0;
        end else if (r_fade_c != '0) begin
            fade = r_fade_c - 1'b1;
        end
    end

    assign o_next_cell = {fade, alive};

endmodule

[hw/rtl/tlg_ctrl.sv]
// sequencer: clearing pass, item handling and the generation sweep
// depends on tlg_pkg; drives both cell stores and the window
module tlg_ctrl #(
    parameter int MAX_COLS = 64,
    parameter int MAX_ROWS = 64,
    parameter int AW       = 12
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic [1:0]                  i_kind,
    input  logic [5:0]                  i_col,
    input  logic [5:0]                  i_row,
    input  logic                        i_alive_in,
    input  logic [tlg_pkg::DIM_W-1:0]   i_eff_w,
    input  logic [tlg_pkg::DIM_W-1:0]   i_eff_h,
    input  logic                        i_out_busy,
    input  logic [tlg_pkg::CELL_W-1:0]  i_rd_data,
    input  logic [tlg_pkg::CELL_W-1:0]  i_next_cell,
    output logic                        o_rd_en,
    output logic [AW-1:0]               o_rd_addr,
    output tlg_pkg::t_wr_sel            o_wr_sel,
    output logic [AW-1:0]               o_wr_addr,
    output logic [tlg_pkg::CELL_W-1:0]  o_wr_data,
    output tlg_pkg::t_win_ctrl          o_win,
    output tlg_pkg::t_res_ctrl          o_res,
    output logic                        o_active
);
    import tlg_pkg::*;

    localparam int CELL_COUNT = MAX_COLS * MAX_ROWS;

    t_state           r_state, n_state;
    logic [AW-1:0]    r_clr_addr, n_clr_addr;
    logic [DIM_W-1:0] r_row, n_row;
    logic [DIM_W:0]   r_step, n_step;
    t_win_row         r_phase, n_phase;
    logic             r_alive, n_alive;
    logic             r_zero, n_zero;
    logic [AW-1:0]    r_addr, n_addr;
    logic             r_active, n_active;
    logic             r_s1_valid, n_s1_valid;
    t_win_row         r_s1_phase;
    logic             r_s1_emit, n_s1_emit;
    logic [AW-1:0]    r_s1_addr;
    logic             r_s2_emit;
    logic [AW-1:0]    r_s2_addr;

    logic             in_grid;
    logic [AW-1:0]    item_addr;
    logic [DIM_W-1:0] src_row;
    logic [DIM_W-1:0] src_col;
    logic [DIM_W:0]   step_m1;
    logic [DIM_W:0]   step_last;
    logic [AW-1:0]    src_addr;
    logic [AW-1:0]    dst_addr;

    assign in_grid   = ({1'b0, i_col} < i_eff_w) && ({1'b0, i_row} < i_eff_h);
    assign item_addr = AW'(int'(i_row) * MAX_COLS + int'(i_col));

    // window column read at step k is k-1, wrapped at both ends
    assign step_m1   = r_step - 1'b1;
    assign step_last = {1'b0, i_eff_w} + 1'b1;

    always_comb begin
        case (r_phase)
            ROW_ABOVE: src_row = (r_row == '0) ? i_eff_h - 1'b1 : r_row - 1'b1;
            ROW_MID:   src_row = r_row;
            ROW_BELOW: src_row = (r_row == i_eff_h - 1'b1) ? '0 : r_row + 1'b1;
            default:   src_row = r_row;
        endcase
        if (r_step == '0) begin
            src_col = i_eff_w - 1'b1;
        end else if (step_m1 == {1'b0, i_eff_w}) begin
            src_col = '0;
        end else begin
            src_col = step_m1[DIM_W-1:0];
        end
    end

    assign src_addr = AW'(int'(src_row) * MAX_COLS + int'(src_col));
    assign dst_addr = AW'(int'(r_row) * MAX_COLS + int'(r_step - 2'd2));

    // next state and counters
    always_comb begin
        n_state    = r_state;
        n_clr_addr = r_clr_addr;
        n_row      = r_row;
        n_step     = r_step;
        n_phase    = r_phase;
        n_alive    = r_alive;
        n_zero     = r_zero;
        n_addr     = r_addr;
        n_active   = r_active;
        case (r_state)
            ST_CLEAR: begin
                n_clr_addr = r_clr_addr + 1'b1;
                if (r_clr_addr == AW'(CELL_COUNT - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_alive = i_alive_in;
                    n_addr  = item_addr;
                    n_zero  = !in_grid;
                    case (i_kind)
                        KIND_WRITE: if (in_grid) n_state = ST_WRITE;
                        KIND_READ:  n_state = ST_RESULT;
                        KIND_STEP: begin
                            n_state = ST_GEN;
                            n_row   = '0;
                            n_step  = '0;
                            n_phase = ROW_ABOVE;
                        end
                        default: ;
                    endcase
                end
            end
            ST_WRITE: n_state = ST_IDLE;
            ST_RESULT: begin
                if (!i_out_busy) begin
                    n_state = ST_IDLE;
                end
            end
            ST_GEN: begin
                case (r_phase)
                    ROW_ABOVE: n_phase = ROW_MID;
                    ROW_MID:   n_phase = ROW_BELOW;
                    default: begin
                        n_phase = ROW_ABOVE;
                        if (r_step == step_last) begin
                            n_step = '0;
                            n_row  = r_row + 1'b1;
                            if (r_row == i_eff_h - 1'b1) begin
                                n_state = ST_DRAIN;
                            end
                        end else begin
                            n_step = r_step + 1'b1;
                        end
                    end
                endcase
            end
            ST_DRAIN: begin
                if (!r_s1_valid && !r_s2_emit) begin
                    n_active = !r_active;
                    n_state  = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_in_ready = (r_state == ST_IDLE);
        o_rd_en    = 1'b0;
        o_rd_addr  = src_addr;
        o_wr_sel   = '0;
        o_wr_addr  = r_s2_addr;
        o_wr_data  = i_next_cell;
        o_res      = '0;
        n_s1_valid = 1'b0;
        n_s1_emit  = 1'b0;
        case (r_state)
            ST_CLEAR: begin
                o_wr_sel.en   = 1'b1;
                o_wr_sel.both = 1'b1;
                o_wr_addr     = r_clr_addr;
                o_wr_data     = '0;
            end
            ST_IDLE: begin
                o_rd_en   = i_in_valid && in_grid;
                o_rd_addr = item_addr;
            end
            ST_WRITE: begin
                o_wr_sel.en = 1'b1;
                o_wr_addr   = r_addr;
                o_wr_data   = {i_rd_data[CELL_W-1:1], r_alive};
            end
            ST_RESULT: begin
                o_res.load = !i_out_busy;
                o_res.zero = r_zero;
            end
            ST_GEN: begin
                o_rd_en    = 1'b1;
                n_s1_valid = 1'b1;
                n_s1_emit  = (r_phase == ROW_BELOW) && (r_step >= 2'd2);
            end
            default: ;
        endcase
        // generation results land in the other store
        if (r_s2_emit) begin
            o_wr_sel.en      = 1'b1;
            o_wr_sel.to_next = 1'b1;
            o_wr_addr        = r_s2_addr;
            o_wr_data        = i_next_cell;
        end
    end

    assign o_win.capture = r_s1_valid;
    assign o_win.row     = r_s1_phase;
    assign o_active      = r_active;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_CLEAR;
            r_clr_addr <= '0;
            r_active   <= 1'b0;
            r_s1_valid <= 1'b0;
            r_s1_emit  <= 1'b0;
            r_s2_emit  <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_clr_addr <= n_clr_addr;
            r_active   <= n_active;
            r_s1_valid <= n_s1_valid;
            r_s1_emit  <= n_s1_emit;
            r_s2_emit  <= r_s1_emit;
        end
    end

    always_ff @(posedge i_clk) begin
        r_row      <= n_row;
        r_step     <= n_step;
        r_phase    <= n_phase;
        r_alive    <= n_alive;
        r_zero     <= n_zero;
        r_addr     <= n_addr;
        r_s1_phase <= r_phase;
        r_s1_addr  <= dst_addr;
        r_s2_addr  <= r_s1_addr;
    end

endmodule

[tb/sv/tb_top.sv]
// testbench of toroidal_life_grid_with_fade: scoreboard check of every read result
// against a predictor of the double-buffered life grid; needs tlg_pkg and the block
`timescale 1ns / 1ps

module tb_top;
    import tlg_pkg::*;

    localparam int GRID_COLS   = 64;
    localparam int GRID_ROWS   = 64;
    localparam int GRID_CELLS  = GRID_COLS * GRID_ROWS;
    localparam int RANDOM_OPS  = 100;
    localparam int STALL_LIMIT = 100000;
    localparam logic [1:0] KIND_UNUSED = 2'd3;

    typedef struct packed {
        logic [4:0] fade;
        logic       alive;
    } t_cell;

    typedef struct {
        logic [1:0] kind;
        logic [5:0] col;
        logic [5:0] row;
        logic       alive;
        bit         drain_first;
    } t_grid_op;

    typedef struct {
        logic       alive;
        logic [4:0] fade;
        logic [2:0] shade;
    } t_cell_view;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       cfg_valid = 1'b0;
    logic [1:0] cfg_index = '0;
    logic [6:0] cfg_data = '0;
    logic       in_valid = 1'b0;
    logic [1:0] in_kind = '0;
    logic [5:0] in_col = '0;
    logic [5:0] in_row = '0;
    logic       in_alive = 1'b0;
    logic       out_ready = 1'b0;
    logic       o_cfg_ready, o_in_ready, o_out_valid, o_alive_out;
    logic [4:0] o_fade_out;
    logic [2:0] o_shade;

    // predictor state
    t_cell      grid_mem [2][GRID_CELLS];
    logic       cur_buf;
    logic [6:0] reg_width;
    logic [6:0] reg_height;
    logic [4:0] reg_fade;

    t_grid_op   op_q[$];
    t_cell_view read_exp_q[$];
    t_grid_op   cur_op;
    bit         no_idle = 1'b0;
    int         errors = 0;
    int         reads_seen = 0;
    int         stall = 0;
    int         op_count = 0;

    always #5 clk = ~clk;

    toroidal_life_grid_with_fade #(
        .MAX_COLS(GRID_COLS),
        .MAX_ROWS(GRID_ROWS)
    ) dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_cfg_valid(cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(cfg_index),
        .i_cfg_data (cfg_data),
        .i_in_valid (in_valid),
        .o_in_ready (o_in_ready),
        .i_kind     (in_kind),
        .i_col      (in_col),
        .i_row      (in_row),
        .i_alive_in (in_alive),
        .o_out_valid(o_out_valid),
        .i_out_ready(out_ready),
        .o_alive_out(o_alive_out),
        .o_fade_out (o_fade_out),
        .o_shade    (o_shade)
    );

    function automatic int eff_width();
        if (reg_width < DIM_MIN) return DIM_MIN;
        if (reg_width > GRID_COLS) return GRID_COLS;
        return reg_width;
    endfunction

    function automatic int eff_height();
        if (reg_height < DIM_MIN) return DIM_MIN;
        if (reg_height > GRID_ROWS) return GRID_ROWS;
        return reg_height;
    endfunction

    function automatic bit on_grid(logic [5:0] col, logic [5:0] row);
        return col < eff_width() && row < eff_height();
    endfunction

    // cycles of one generation at the current size, with some slack
    function automatic int gen_cycles();
        return 3 * eff_height() * (eff_width() + 2) + 20;
    endfunction

    // bands of four fade values, dim to bright
    function automatic logic [2:0] expected_shade(t_cell c);
        if (c.alive) return SHADE_ALIVE;
        if (c.fade > FADE_LIMIT) return SHADE_BLACK;
        return 3'((int'(c.fade) + 3) / 4);
    endfunction

    task automatic run_generation();
        int    w, h, r, c, dr, dc, nbr;
        logic  [4:0] dead_fade;
        t_cell cur, nxt;
        w = eff_width();
        h = eff_height();
        dead_fade = (reg_fade > FADE_LIMIT) ? FADE_LIMIT : reg_fade;
        for (r = 0; r < h; r++) begin
            for (c = 0; c < w; c++) begin
                nbr = 0;
                for (dr = 0; dr < 3; dr++) begin
                    for (dc = 0; dc < 3; dc++) begin
                        if (dr != 1 || dc != 1) begin
                            nbr += grid_mem[cur_buf][((r + h - 1 + dr) % h) * GRID_COLS
                                                     + (c + w - 1 + dc) % w].alive;
                        end
                    end
                end
                cur = grid_mem[cur_buf][r * GRID_COLS + c];
                nxt = cur;
                if (cur.alive && (nbr < SURVIVE_MIN || nbr > BIRTH_COUNT)) begin
                    nxt.alive = 1'b0;
                    nxt.fade  = dead_fade;
                end else if (!cur.alive && nbr == BIRTH_COUNT) begin
                    nxt.alive = 1'b1;
                    nxt.fade  = '0;
                end else if (nxt.fade != 0) begin
                    nxt.fade = nxt.fade - 1'b1;
                end
                grid_mem[~cur_buf][r * GRID_COLS + c] = nxt;
            end
        end
        cur_buf = ~cur_buf;
    endtask

    task automatic predict_op(t_grid_op op);
        t_cell_view view;
        t_cell      c;
        case (op.kind)
            KIND_WRITE: begin
                if (on_grid(op.col, op.row)) begin
                    grid_mem[cur_buf][op.row * GRID_COLS + op.col].alive = op.alive;
                end
            end
            KIND_READ: begin
                view = '{1'b0, 5'd0, SHADE_BLACK};
                if (on_grid(op.col, op.row)) begin
                    c = grid_mem[cur_buf][op.row * GRID_COLS + op.col];
                    view = '{c.alive, c.fade, expected_shade(c)};
                end
                read_exp_q.push_back(view);
            end
            KIND_STEP: run_generation();
            default: ;
        endcase
    endtask

    task automatic report_error(string msg);
        errors++;
        $display("[%0t] mismatch: %s", $realtime, msg);
    endtask

    function automatic void push_op(logic [1:0] kind, logic [5:0] col, logic [5:0] row,
                                    logic alive, bit drain_first = 1'b0);
        t_grid_op op;
        op = '{kind, col, row, alive, drain_first};
        op_q.push_back(op);
    endfunction

    task automatic write_reg(t_cfg_idx idx, logic [6:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!o_cfg_ready) @(posedge clk);
        case (idx)
            CFG_GRID_WIDTH:  reg_width  = val;
            CFG_GRID_HEIGHT: reg_height = val;
            CFG_FADE_START:  reg_fade   = val[4:0];
            default: ;
        endcase
    endtask

    task automatic set_config(logic [6:0] w, logic [6:0] h, logic [6:0] fs);
        write_reg(CFG_GRID_WIDTH, w);
        write_reg(CFG_GRID_HEIGHT, h);
        write_reg(CFG_FADE_START, fs);
        cfg_valid <= 1'b0;
    endtask

    // block has drained and no generation can still be running
    task automatic wait_idle();
        while (op_q.size() != 0 || in_valid || read_exp_q.size() != 0) @(posedge clk);
        repeat (gen_cycles()) @(posedge clk);
    endtask

    function automatic void push_noise();
        push_op(2'($urandom_range(0, 3)), 6'($urandom_range(0, 63)),
                6'($urandom_range(0, 63)), 1'($urandom_range(0, 1)));
    endfunction

    // seed a pattern, then run a few generations and read cells back
    function automatic void build_random_phase();
        int n_seed, rounds, n_reads, n_writes, i, k;
        n_seed = $urandom_range(4, 12);
        for (i = 0; i < n_seed; i++) begin
            if ($urandom_range(0, 99) < 10) push_noise();
            push_op(KIND_WRITE, 6'($urandom_range(0, eff_width() - 1)),
                    6'($urandom_range(0, eff_height() - 1)), $urandom_range(0, 99) < 60);
            op_count++;
        end
        rounds = $urandom_range(1, 3);
        for (k = 0; k < rounds; k++) begin
            push_op(KIND_STEP, 6'($urandom_range(0, 63)), 6'($urandom_range(0, 63)),
                    1'($urandom_range(0, 1)));
            op_count++;
            n_reads = $urandom_range(2, 6);
            for (i = 0; i < n_reads; i++) begin
                if ($urandom_range(0, 99) < 10) push_noise();
                push_op(KIND_READ, 6'($urandom_range(0, eff_width() - 1)),
                        6'($urandom_range(0, eff_height() - 1)), 1'($urandom_range(0, 1)),
                        i == 0 && $urandom_range(0, 99) < 30);
                op_count++;
            end
            n_writes = $urandom_range(0, 3);
            for (i = 0; i < n_writes; i++) begin
                push_op(KIND_WRITE, 6'($urandom_range(0, eff_width() - 1)),
                        6'($urandom_range(0, eff_height() - 1)), 1'($urandom_range(0, 1)));
                op_count++;
            end
        end
    endfunction

    // input driver
    always @(posedge clk) begin : drive
        bit fired;
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else begin
            fired = in_valid && o_in_ready;
            if (fired) predict_op(cur_op);
            if (!in_valid || fired) begin
                if (op_q.size() != 0
                        && !(op_q[0].drain_first && read_exp_q.size() != 0)
                        && (no_idle || $urandom_range(0, 99) >= 17)) begin
                    cur_op   = op_q.pop_front();
                    in_valid <= 1'b1;
                    in_kind  <= cur_op.kind;
                    in_col   <= cur_op.col;
                    in_row   <= cur_op.row;
                    in_alive <= cur_op.alive;
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // result monitor
    always @(posedge clk) begin : check
        t_cell_view want;
        if (!rst_n) begin
            out_ready <= 1'b0;
        end else begin
            if (o_out_valid && out_ready) begin
                reads_seen++;
                if (read_exp_q.size() == 0) begin
                    report_error($sformatf("result %0d arrived with no read pending",
                                           reads_seen));
                end else begin
                    want = read_exp_q.pop_front();
                    if (o_alive_out !== want.alive)
                        report_error($sformatf("result %0d alive_out got %0d want %0d",
                                               reads_seen, o_alive_out, want.alive));
                    if (o_fade_out !== want.fade)
                        report_error($sformatf("result %0d fade_out got %0d want %0d",
                                               reads_seen, o_fade_out, want.fade));
                    if (o_shade !== want.shade)
                        report_error($sformatf("result %0d shade got %0d want %0d",
                                               reads_seen, o_shade, want.shade));
                end
            end
            out_ready <= no_idle || $urandom_range(0, 99) >= 17;
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge clk) begin
        if (!rst_n || (in_valid && o_in_ready) || (o_out_valid && out_ready)
                || (cfg_valid && o_cfg_ready)) begin
            stall <= 0;
        end else if (stall >= STALL_LIMIT) begin
            $display("simulation failed");
            $finish;
        end else begin
            stall <= stall + 1;
        end
    end

    initial begin
        foreach (grid_mem[b, i]) grid_mem[b][i] = '0;
        cur_buf    = 1'b0;
        reg_width  = 7'd64;
        reg_height = 7'd64;
        reg_fade   = 5'd20;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // full-size grid: blinker across the wrap corner plus a lone cell
        push_op(KIND_READ, 6'd0, 6'd0, 1'b0);
        push_op(KIND_WRITE, 6'd63, 6'd0, 1'b1);
        push_op(KIND_WRITE, 6'd0, 6'd0, 1'b1);
        push_op(KIND_WRITE, 6'd1, 6'd0, 1'b1);
        push_op(KIND_WRITE, 6'd32, 6'd32, 1'b1);
        push_op(KIND_WRITE, 6'd40, 6'd63, 1'b1);
        push_op(KIND_WRITE, 6'd40, 6'd63, 1'b0);
        push_op(KIND_READ, 6'd0, 6'd0, 1'b1);
        push_op(KIND_UNUSED, 6'd63, 6'd63, 1'b1);
        push_op(KIND_STEP, 6'd0, 6'd0, 1'b0);
        push_op(KIND_READ, 6'd0, 6'd63, 1'b0, 1'b1);
        push_op(KIND_READ, 6'd63, 6'd0, 1'b0);
        push_op(KIND_STEP, 6'd0, 6'd0, 1'b0);
        push_op(KIND_READ, 6'd0, 6'd63, 1'b0);
        push_op(KIND_READ, 6'd63, 6'd0, 1'b0);
        push_op(KIND_READ, 6'd32, 6'd32, 1'b0);
        push_op(KIND_READ, 6'd40, 6'd63, 1'b0);
        wait_idle();

        // sizes below the minimum, dead cells keep no fade
        set_config(7'd0, 7'd2, 7'd0);
        push_op(KIND_WRITE, 6'd2, 6'd2, 1'b1);
        push_op(KIND_WRITE, 6'd0, 6'd0, 1'b1);
        push_op(KIND_WRITE, 6'd1, 6'd1, 1'b1);
        push_op(KIND_WRITE, 6'd63, 6'd63, 1'b1);
        push_op(KIND_STEP, 6'd0, 6'd0, 1'b0);
        push_op(KIND_READ, 6'd1, 6'd0, 1'b0);
        push_op(KIND_READ, 6'd3, 6'd0, 1'b0);
        push_op(KIND_STEP, 6'd0, 6'd0, 1'b0);
        push_op(KIND_READ, 6'd2, 6'd2, 1'b0);
        push_op(KIND_READ, 6'd63, 6'd63, 1'b0);
        wait_idle();

        // oversized width with fade start above its limit
        set_config(7'd127, 7'd3, 7'd31);
        no_idle = 1'b1;
        build_random_phase();
        wait_idle();
        no_idle = 1'b0;

        while (op_count < RANDOM_OPS) begin
            case ($urandom_range(0, 5))
                0: set_config(7'($urandom_range(0, 2)), 7'($urandom_range(3, 10)),
                              7'($urandom_range(0, 127)));
                1: set_config(7'($urandom_range(65, 127)), 7'($urandom_range(0, 4)),
                              7'($urandom_range(0, 127)));
                2: set_config(7'($urandom_range(3, 5)), 7'($urandom_range(65, 127)),
                              7'($urandom_range(0, 127)));
                default: set_config(7'($urandom_range(3, 12)), 7'($urandom_range(3, 12)),
                                    7'($urandom_range(0, 127)));
            endcase
            build_random_phase();
            wait_idle();
        end

        if (errors == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

[sim.f]
hw/rtl/tlg_pkg.sv
hw/rtl/tlg_cell_mem.sv
hw/rtl/tlg_window.sv
hw/rtl/tlg_ctrl.sv
hw/rtl/toroidal_life_grid_with_fade.sv
tb/sv/tb_top.sv
